/* hdl/pcm_multichannel_downmix_to_mono_macros.svh */
// assertion macros used by the downmix back end
`ifndef PCM_MULTICHANNEL_DOWNMIX_TO_MONO_MACROS_SVH
`define PCM_MULTICHANNEL_DOWNMIX_TO_MONO_MACROS_SVH

// same-cycle implication, disabled during reset
`define PCMDM_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("pcmdm assertion failed");

// next-cycle implication, disabled during reset
`define PCMDM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("pcmdm assertion failed");

`endif

/* hdl/pcmdm_pkg.sv */
// shared types, constants and sample conversion for the downmix block
package pcmdm_pkg;

  localparam int MAX_CHANNELS = 64;
  localparam int SAMPLE_W     = 32;
  localparam int SUM_W        = SAMPLE_W + $clog2(MAX_CHANNELS);
  localparam int TALLY_W      = $clog2(MAX_CHANNELS + 1);
  localparam int SEQ_W        = 32;
  localparam int CFG_IDX_W    = 8;
  localparam int CFG_DATA_W   = 32;
  localparam int FIFO_DEPTH   = 2;
  localparam int FIFO_PTR_W   = $clog2(FIFO_DEPTH);
  localparam int FIFO_CNT_W   = $clog2(FIFO_DEPTH + 1);
  localparam int DIV_CNT_W    = $clog2(SUM_W);

  localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_FORMAT  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_CAPTURE_ENABLE = CFG_IDX_W'(1);

  localparam logic [7:0] FLT_EXP_MAX  = 8'hFF;
  localparam logic [7:0] FLT_EXP_ONE  = 8'd127;
  localparam logic [7:0] FLT_EXP_TOP  = 8'd126;
  localparam logic [7:0] FLT_SHIFT_LIM = 8'd30;

  typedef enum logic [1:0] {
    FMT_INT16   = 2'd0,
    FMT_INT24   = 2'd1,
    FMT_INT32   = 2'd2,
    FMT_FLOAT32 = 2'd3
  } sample_format_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_DONE
  } div_state_e;

  typedef struct packed {
    logic signed [SUM_W-1:0] sum;
    logic [TALLY_W-1:0]      tally;
    logic [SEQ_W-1:0]        seq;
    logic                    pkt_end;
  } frame_rec_t;

  typedef struct packed {
    logic       valid;
    frame_rec_t rec;
  } rec_chan_t;

  function automatic logic signed [SAMPLE_W-1:0] float_to_q31(input logic [31:0] w);
    logic        neg;
    logic [7:0]  ex;
    logic [22:0] man;
    logic [30:0] mv;
    logic [7:0]  shamt;
    logic [30:0] mag;
    logic signed [SAMPLE_W-1:0] res;
    neg   = w[31];
    ex    = w[30:23];
    man   = w[22:0];
    mv    = {1'b1, man, 7'b0};
    shamt = FLT_EXP_TOP - ex;
    mag   = (shamt > FLT_SHIFT_LIM) ? '0 : (mv >> shamt);
    if (ex == FLT_EXP_MAX && man != '0) begin
      res = '0;
    end else if (ex >= FLT_EXP_ONE) begin
      res = neg ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
    end else if (ex == '0) begin
      res = '0;
    end else begin
      res = neg ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
    end
    return res;
  endfunction

  function automatic logic signed [SAMPLE_W-1:0] to_q31(input sample_format_e fmt,
                                                        input logic [31:0] w);
    logic signed [SAMPLE_W-1:0] res;
    case (fmt)
      FMT_INT16: res = $signed({w[15:0], 16'b0});
      FMT_INT24: res = $signed({w[23:0], 8'b0});
      FMT_INT32: res = $signed(w);
      default:   res = float_to_q31(w);
    endcase
    return res;
  endfunction

endpackage

/* hdl/pcmdm_front.sv */
// front end: config registers, sample conversion, frame accumulation
module pcmdm_front (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [pcmdm_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [pcmdm_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  logic                            push_i,
  output logic                            full_o,
  input  logic [31:0]                     sample_word_i,
  input  logic                            last_in_frame_i,
  input  logic                            last_in_packet_i,
  output pcmdm_pkg::rec_chan_t            rec_o,
  input  logic                            rec_full_i
);
  import pcmdm_pkg::*;

  sample_format_e fmt_q;
  logic           en_q;

  logic                       s1_valid_q, s1_valid_d;
  logic signed [SAMPLE_W-1:0] s1_val_q;
  logic                       s1_lf_q, s1_lp_q;
  logic                       s1_adv, in_acc, acc_go;

  logic signed [SUM_W-1:0] sum_q, sum_d, sum_new;
  logic [TALLY_W-1:0]      tally_q, tally_d, tally_new;
  logic [SEQ_W-1:0]        pkt_q, pkt_d;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fmt_q <= FMT_INT16;
      en_q  <= 1'b0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        REG_SAMPLE_FORMAT:  fmt_q <= sample_format_e'(cfg_data_i[1:0]);
        REG_CAPTURE_ENABLE: en_q  <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  assign s1_adv = !(s1_lf_q && rec_full_i);
  assign full_o = s1_valid_q && !s1_adv;
  assign in_acc = push_i && !full_o;
  assign acc_go = s1_valid_q && s1_adv;

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (in_acc) begin
      s1_valid_d = en_q;
    end else if (s1_adv) begin
      s1_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_val_q <= to_q31(fmt_q, sample_word_i);
      s1_lf_q  <= last_in_frame_i;
      s1_lp_q  <= last_in_packet_i;
    end
  end

  // channels beyond the limit are dropped from the mean
  always_comb begin
    sum_new   = sum_q;
    tally_new = tally_q;
    if (tally_q < TALLY_W'(MAX_CHANNELS)) begin
      sum_new   = sum_q + SUM_W'(s1_val_q);
      tally_new = tally_q + TALLY_W'(1);
    end
  end

  always_comb begin
    sum_d   = sum_q;
    tally_d = tally_q;
    pkt_d   = pkt_q;
    if (acc_go) begin
      if (s1_lf_q) begin
        sum_d   = '0;
        tally_d = '0;
        pkt_d   = pkt_q + SEQ_W'(s1_lp_q);
      end else begin
        sum_d   = sum_new;
        tally_d = tally_new;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q   <= '0;
      tally_q <= '0;
      pkt_q   <= '0;
    end else begin
      sum_q   <= sum_d;
      tally_q <= tally_d;
      pkt_q   <= pkt_d;
    end
  end

  assign rec_o.valid       = acc_go && s1_lf_q;
  assign rec_o.rec.sum     = sum_new;
  assign rec_o.rec.tally   = tally_new;
  assign rec_o.rec.seq     = pkt_q;
  assign rec_o.rec.pkt_end = s1_lp_q;

endmodule

/* hdl/pcmdm_fifo.sv */
// short frame queue between front end and divider
module pcmdm_fifo (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  pcmdm_pkg::rec_chan_t  wr_i,
  output logic                  full_o,
  output pcmdm_pkg::rec_chan_t  rd_o,
  input  logic                  pop_i
);
  import pcmdm_pkg::*;

  frame_rec_t              mem_q [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0]   wr_ptr_q, rd_ptr_q;
  logic [FIFO_CNT_W-1:0]   cnt_q;
  logic                    do_wr, do_rd;

  assign full_o   = (cnt_q == FIFO_CNT_W'(FIFO_DEPTH));
  assign rd_o.valid = (cnt_q != '0);
  assign rd_o.rec   = mem_q[rd_ptr_q];
  assign do_wr    = wr_i.valid && !full_o;
  assign do_rd    = pop_i && rd_o.valid;

  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem_q[wr_ptr_q] <= wr_i.rec;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr_q <= (wr_ptr_q == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_rd) begin
        rd_ptr_q <= (rd_ptr_q == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      cnt_q <= cnt_q + FIFO_CNT_W'(do_wr) - FIFO_CNT_W'(do_rd);
    end
  end

endmodule

/* hdl/pcmdm_back.sv */
// back end: serial signed divider and result register
module pcmdm_back (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  pcmdm_pkg::rec_chan_t rec_i,
  output logic                 rec_pop_o,
  output logic                 empty_o,
  input  logic                 pop_i,
  output logic signed [31:0]   mono_sample_o,
  output logic [31:0]          packet_sequence_o,
  output logic                 packet_end_o
);
  import pcmdm_pkg::*;

  `include "pcm_multichannel_downmix_to_mono_macros.svh"

  div_state_e st_q, st_d;

  logic [SUM_W-1:0]     q_q, q_d;
  logic [TALLY_W-1:0]   rem_q, rem_d;
  logic [TALLY_W-1:0]   dvs_q;
  logic [DIV_CNT_W-1:0] cnt_q, cnt_d;
  logic                 neg_q;
  logic [SEQ_W-1:0]     seq_q;
  logic                 pend_q;

  logic [TALLY_W:0]     shifted;
  logic [TALLY_W+1:0]   trial;
  logic                 ge;
  logic                 load, out_wr, out_take;
  logic [SUM_W-1:0]     signed_q;
  logic                 out_valid_q;

  assign shifted  = {rem_q, q_q[SUM_W-1]};
  assign trial    = {1'b0, shifted} - {2'b00, dvs_q};
  assign ge       = !trial[TALLY_W+1];
  assign out_take = pop_i && out_valid_q;
  assign signed_q = neg_q ? (~q_q + SUM_W'(1)) : q_q;

  always_comb begin
    st_d      = st_q;
    q_d       = q_q;
    rem_d     = rem_q;
    cnt_d     = cnt_q;
    load      = 1'b0;
    out_wr    = 1'b0;
    rec_pop_o = 1'b0;
    unique case (st_q)
      ST_IDLE: begin
        if (rec_i.valid) begin
          rec_pop_o = 1'b1;
          load      = 1'b1;
          st_d      = ST_DIV;
        end
      end
      ST_DIV: begin
        q_d   = {q_q[SUM_W-2:0], ge};
        rem_d = ge ? trial[TALLY_W-1:0] : shifted[TALLY_W-1:0];
        cnt_d = cnt_q + DIV_CNT_W'(1);
        if (cnt_q == DIV_CNT_W'(SUM_W - 1)) begin
          st_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid_q || out_take) begin
          out_wr = 1'b1;
          st_d   = ST_IDLE;
        end
      end
      default: st_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      st_q <= st_d;
      if (out_wr) begin
        out_valid_q <= 1'b1;
      end else if (out_take) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      neg_q  <= rec_i.rec.sum[SUM_W-1];
      q_q    <= rec_i.rec.sum[SUM_W-1] ? SUM_W'(-rec_i.rec.sum) : SUM_W'(rec_i.rec.sum);
      rem_q  <= '0;
      dvs_q  <= rec_i.rec.tally;
      cnt_q  <= '0;
      seq_q  <= rec_i.rec.seq;
      pend_q <= rec_i.rec.pkt_end;
    end else begin
      q_q   <= q_d;
      rem_q <= rem_d;
      cnt_q <= cnt_d;
    end
    if (out_wr) begin
      mono_sample_o     <= (dvs_q == '0) ? '0 : $signed(signed_q[31:0]);
      packet_sequence_o <= seq_q;
      packet_end_o      <= pend_q;
    end
  end

  assign empty_o = !out_valid_q;

  `PCMDM_ASSERT_NEXT(a_load_starts_div, clk_i, rst_ni, st_q == ST_IDLE && rec_i.valid,
                     st_q == ST_DIV)
  `PCMDM_ASSERT_IMPL(a_divisor_nonzero, clk_i, rst_ni, st_q == ST_DIV, dvs_q != '0)
  `PCMDM_ASSERT_IMPL(a_quotient_fits, clk_i, rst_ni, st_q == ST_DONE, (q_q >> 32) == '0)
  `PCMDM_ASSERT_IMPL(a_pop_only_idle, clk_i, rst_ni, rec_pop_o, st_q == ST_IDLE)

endmodule

/* hdl/pcm_multichannel_downmix_to_mono.sv */
// top level of the multichannel pcm downmix to mono block
// Usage:
// - samples enter as items on push_i/full_o, one raw channel sample each, in the
//   format chosen by register 0; register 1 gates capture
// - config writes use cfg_valid_i/cfg_ready_o, index and data; ready is always high
//   and writes are meant for an idle block
// - results leave on empty_o/pop_i, one mono item per frame, oldest first
// - each accepted sample is converted into the input stage register and then summed;
//   a sample can be taken every cycle unless a finished frame finds the queue full
// - a frame result passes from the input stage through the queue and the divider
//   states idle, div and done into the result register; the divider takes a new
//   frame only back in idle, one quotient bit per cycle in the back end
// - a two-entry queue sits between the accumulator and the divider
// - while pop_i is low the result holds; the divider finishes its frame and waits,
//   then the queue fills, then full_o rises on the next frame end
// - reset clears the accumulator, channel count, packet counter, queue and result flag,
//   sets format to int16 and disables capture
// - disabled capture accepts and discards samples
module pcm_multichannel_downmix_to_mono (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [pcmdm_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [pcmdm_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  logic                            push_i,
  output logic                            full_o,
  input  logic [31:0]                     sample_word_i,
  input  logic                            last_in_frame_i,
  input  logic                            last_in_packet_i,
  output logic                            empty_o,
  input  logic                            pop_i,
  output logic signed [31:0]              mono_sample_o,
  output logic [31:0]                     packet_sequence_o,
  output logic                            packet_end_o
);
  import pcmdm_pkg::*;

  rec_chan_t front_rec, fifo_rec;
  logic      fifo_full, fifo_pop;

  pcmdm_front u_front (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_o      (cfg_ready_o),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i),
    .push_i           (push_i),
    .full_o           (full_o),
    .sample_word_i    (sample_word_i),
    .last_in_frame_i  (last_in_frame_i),
    .last_in_packet_i (last_in_packet_i),
    .rec_o            (front_rec),
    .rec_full_i       (fifo_full)
  );

  pcmdm_fifo u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .wr_i   (front_rec),
    .full_o (fifo_full),
    .rd_o   (fifo_rec),
    .pop_i  (fifo_pop)
  );

  pcmdm_back u_back (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .rec_i             (fifo_rec),
    .rec_pop_o         (fifo_pop),
    .empty_o           (empty_o),
    .pop_i             (pop_i),
    .mono_sample_o     (mono_sample_o),
    .packet_sequence_o (packet_sequence_o),
    .packet_end_o      (packet_end_o)
  );

endmodule

/* bench/tb_pcm_multichannel_downmix_to_mono.sv */
// self-checking testbench for the pcm multichannel downmix to mono block
`timescale 1ns / 1ps

module tb_pcm_multichannel_downmix_to_mono;
  import pcmdm_pkg::*;

  localparam int TARGET_ITEMS  = 1700;
  localparam int SETTLE_CYCLES = SUM_W + 20;
  localparam int HOLD_CYCLES   = 600;
  localparam int CYCLE_LIMIT   = 600000;
  localparam int MAX_REPORTS   = 10;

  typedef struct {
    bit [31:0] word;
    bit        frame_end;
    bit        packet_end;
  } pcm_item_t;

  typedef struct {
    bit [31:0] mono;
    bit [31:0] seq;
    bit        pend;
  } mono_result_t;

  logic                  clk_i            = 1'b0;
  logic                  rst_ni           = 1'b0;
  logic                  cfg_valid_i      = 1'b0;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i      = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i       = '0;
  logic                  push_i           = 1'b0;
  logic                  full_o;
  logic [31:0]           sample_word_i    = '0;
  logic                  last_in_frame_i  = 1'b0;
  logic                  last_in_packet_i = 1'b0;
  logic                  empty_o;
  logic                  pop_i            = 1'b0;
  logic signed [31:0]    mono_sample_o;
  logic [31:0]           packet_sequence_o;
  logic                  packet_end_o;

  pcm_multichannel_downmix_to_mono u_top (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_o      (cfg_ready_o),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i),
    .push_i           (push_i),
    .full_o           (full_o),
    .sample_word_i    (sample_word_i),
    .last_in_frame_i  (last_in_frame_i),
    .last_in_packet_i (last_in_packet_i),
    .empty_o          (empty_o),
    .pop_i            (pop_i),
    .mono_sample_o    (mono_sample_o),
    .packet_sequence_o(packet_sequence_o),
    .packet_end_o     (packet_end_o)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  pcm_item_t      sample_pending_q[$];
  mono_result_t   mono_due_q[$];
  pcm_item_t      cur_item;

  sample_format_e cfg_fmt     = FMT_INT16;
  bit             cfg_capture = 1'b0;
  longint         mix_sum     = 0;
  int             mix_tally   = 0;
  bit [31:0]      seq_count   = '0;

  int  mismatch_cnt  = 0;
  int  cycle_cnt     = 0;
  int  tx_done_cnt   = 0;
  int  tx_seen_cnt   = 0;
  int  tx_wait       = 0;
  bit  tx_burst      = 1'b0;
  bit  tx_flood      = 1'b0;
  int  rx_done_cnt   = 0;
  int  rx_seen_cnt   = 0;
  int  rx_wait       = 0;
  bit  rx_burst      = 1'b0;
  int  hold_req_cnt  = 0;
  int  hold_seen_cnt = 0;
  int  hold_left     = 0;

  function automatic longint q31_of_float(input bit [31:0] w);
    bit       neg = w[31];
    bit [7:0] ex  = w[30:23];
    bit [22:0] man = w[22:0];
    longint   mag;
    if (ex == 8'hFF && man != '0) return 0;
    if (ex >= 8'd127) return neg ? -64'sd2147483648 : 64'sd2147483647;
    if (ex == 8'd0) return 0;
    mag = longint'({1'b1, man});
    if (ex >= 8'd119) begin
      mag = mag << (ex - 8'd119);
    end else if (8'd119 - ex >= 8'd24) begin
      mag = 0;
    end else begin
      mag = mag >> (8'd119 - ex);
    end
    return neg ? -mag : mag;
  endfunction

  function automatic longint q31_of_word(input sample_format_e fmt, input bit [31:0] w);
    case (fmt)
      FMT_INT16: return longint'($signed(w[15:0])) * 65536;
      FMT_INT24: return longint'($signed(w[23:0])) * 256;
      FMT_INT32: return longint'($signed(w));
      default:   return q31_of_float(w);
    endcase
  endfunction

  // accumulate one accepted sample and queue the frame mean on a frame end
  task automatic downmix_accept(input pcm_item_t it);
    mono_result_t r;
    longint       mean;
    if (!cfg_capture) return;
    if (mix_tally < MAX_CHANNELS) begin
      mix_sum   += q31_of_word(cfg_fmt, it.word);
      mix_tally += 1;
    end
    if (!it.frame_end) return;
    mean   = (mix_tally != 0) ? mix_sum / mix_tally : 0;
    r.mono = mean[31:0];
    r.seq  = seq_count;
    r.pend = it.packet_end;
    mono_due_q.push_back(r);
    mix_sum   = 0;
    mix_tally = 0;
    if (it.packet_end) seq_count += 1;
  endtask

  function automatic int draw_gap(inout bit burst);
    if ($urandom_range(0, 24) == 0) burst = !burst;
    return burst ? 0 : $urandom_range(0, 11);
  endfunction

  function automatic void note_mismatch(input string msg);
    mismatch_cnt++;
    if (mismatch_cnt <= MAX_REPORTS) $display("mismatch: %s", msg);
  endfunction

  // sample side
  always @(posedge clk_i) begin
    if (rst_ni && push_i && !full_o) begin
      downmix_accept(cur_item);
      tx_done_cnt++;
    end
  end

  always @(negedge clk_i) begin : tx_drive
    bit free;
    free = !push_i;
    if (tx_done_cnt != tx_seen_cnt) begin
      tx_seen_cnt = tx_done_cnt;
      free        = 1'b1;
      tx_wait     = tx_flood ? 0 : draw_gap(tx_burst);
    end
    if (rst_ni && free) begin
      if (tx_wait > 0) begin
        tx_wait--;
        push_i <= 1'b0;
      end else if (sample_pending_q.size() != 0) begin
        cur_item = sample_pending_q.pop_front();
        sample_word_i    <= cur_item.word;
        last_in_frame_i  <= cur_item.frame_end;
        last_in_packet_i <= cur_item.packet_end;
        push_i           <= 1'b1;
      end else begin
        push_i <= 1'b0;
      end
    end
  end

  // result side
  always @(posedge clk_i) begin : rx_check
    mono_result_t want;
    if (rst_ni && pop_i && !empty_o) begin
      rx_done_cnt++;
      if (mono_due_q.size() == 0) begin
        note_mismatch($sformatf("unexpected item mono=%h seq=%h end=%b",
                                mono_sample_o, packet_sequence_o, packet_end_o));
      end else begin
        want = mono_due_q.pop_front();
        if (mono_sample_o !== want.mono || packet_sequence_o !== want.seq ||
            packet_end_o !== want.pend) begin
          note_mismatch($sformatf("exp mono=%h seq=%h end=%b got mono=%h seq=%h end=%b",
                                  want.mono, want.seq, want.pend, mono_sample_o,
                                  packet_sequence_o, packet_end_o));
        end
      end
    end
  end

  always @(negedge clk_i) begin
    if (hold_req_cnt != hold_seen_cnt) begin
      hold_seen_cnt = hold_req_cnt;
      hold_left     = HOLD_CYCLES;
    end
    if (rx_done_cnt != rx_seen_cnt) begin
      rx_seen_cnt = rx_done_cnt;
      rx_wait     = draw_gap(rx_burst);
    end
    if (!rst_ni) begin
      pop_i <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      pop_i <= 1'b0;
    end else if (rx_wait > 0) begin
      rx_wait--;
      pop_i <= 1'b0;
    end else begin
      pop_i <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_cnt);
      $display("*** FAILED ***");
      $finish;
    end
  end

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    if (idx == REG_SAMPLE_FORMAT) cfg_fmt = sample_format_e'(data[1:0]);
    else if (idx == REG_CAPTURE_ENABLE) cfg_capture = data[0];
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic wait_idle();
    while (sample_pending_q.size() != 0 || push_i || mono_due_q.size() != 0)
      @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic queue_item(input bit [31:0] word, input bit fe, input bit pe);
    pcm_item_t it;
    it.word       = word;
    it.frame_end  = fe;
    it.packet_end = pe;
    sample_pending_q.push_back(it);
  endtask

  function automatic bit [31:0] pick_word(input sample_format_e fmt);
    int        r = $urandom_range(0, 9);
    bit [31:0] w = $urandom;
    if (fmt == FMT_FLOAT32) begin
      case (r)
        0: w[30:23] = 8'hFF;
        1: w[30:23] = 8'($urandom_range(127, 254));
        2: w[30:23] = (w[0]) ? 8'h00 : 8'd127;
        default: w[30:23] = 8'($urandom_range(90, 126));
      endcase
    end else if (r == 0 || r == 1) begin
      case (fmt)
        FMT_INT16: w[15:0] = (r == 0) ? 16'h7FFF : 16'h8000;
        FMT_INT24: w[23:0] = (r == 0) ? 24'h7F_FFFF : 24'h80_0000;
        default:   w       = (r == 0) ? 32'h7FFF_FFFF : 32'h8000_0000;
      endcase
    end
    return w;
  endfunction

  task automatic queue_frames(input int n, input bit single);
    int left = n;
    int flen;
    int r;
    while (left > 0) begin
      r    = $urandom_range(0, 39);
      flen = single ? 1 : (r == 0) ? $urandom_range(62, 70) :
             (r < 8) ? 1 : $urandom_range(2, 8);
      for (int i = 0; i < flen && left > 0; i++) begin
        if (i == flen - 1) queue_item(pick_word(cfg_fmt), 1'b1, $urandom_range(0, 3) == 0);
        else queue_item(pick_word(cfg_fmt), 1'b0, $urandom_range(0, 7) == 0);
        left--;
      end
    end
  endtask

  initial begin
    int n;
    int total;
    int ph;
    total = 0;
    repeat (6) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // capture still off after reset
    queue_item(32'h1234_5678, 1'b0, 1'b0);
    queue_item(32'hDEAD_BEEF, 1'b1, 1'b1);
    wait_idle();
    write_reg(CFG_IDX_W'(9), 32'hFFFF_FFFF);
    write_reg(REG_SAMPLE_FORMAT, 32'hFFFF_FFFC);
    write_reg(REG_CAPTURE_ENABLE, 32'hFFFF_FFFF);
    @(posedge clk_i);
    queue_item(32'hA5A5_7FFF, 1'b0, 1'b0);
    queue_item(32'h1234_0001, 1'b0, 1'b1);
    queue_item(32'hFFFF_8000, 1'b1, 1'b1);
    wait_idle();
    write_reg(REG_SAMPLE_FORMAT, 32'h0000_0005);
    @(posedge clk_i);
    queue_item(32'h007F_FFFF, 1'b0, 1'b0);
    queue_item(32'hFF80_0000, 1'b1, 1'b0);
    queue_item(32'h00FF_FFFF, 1'b1, 1'b1);
    wait_idle();
    write_reg(REG_SAMPLE_FORMAT, CFG_DATA_W'(FMT_INT32));
    @(posedge clk_i);
    queue_item(32'h7FFF_FFFF, 1'b0, 1'b0);
    queue_item(32'h8000_0000, 1'b1, 1'b0);
    queue_item(32'hFFFF_FFFF, 1'b1, 1'b1);
    queue_item(32'h4000_0000, 1'b0, 1'b0);
    wait_idle();
    // format switch in the middle of a frame
    write_reg(REG_SAMPLE_FORMAT, CFG_DATA_W'(FMT_FLOAT32));
    @(posedge clk_i);
    queue_item(32'h3F80_0000, 1'b0, 1'b0);
    queue_item(32'hBF80_0000, 1'b1, 1'b0);
    queue_item(32'h7F80_0000, 1'b0, 1'b0);
    queue_item(32'hFF80_0000, 1'b1, 1'b1);
    queue_item(32'h7FC0_0000, 1'b0, 1'b0);
    queue_item(32'h0000_0001, 1'b0, 1'b0);
    queue_item(32'h8000_0000, 1'b1, 1'b0);
    queue_item(32'h3F00_0000, 1'b0, 1'b0);
    queue_item(32'h3380_0000, 1'b0, 1'b0);
    queue_item(32'hBF7F_FFFF, 1'b1, 1'b0);
    queue_item(32'hFFFF_FFFF, 1'b1, 1'b1);

    ph = 0;
    while (total < TARGET_ITEMS) begin
      wait_idle();
      tx_flood = 1'b0;
      write_reg(REG_SAMPLE_FORMAT, (ph < 4) ? {30'($urandom), 2'(ph)} : $urandom);
      write_reg(REG_CAPTURE_ENABLE, {31'($urandom), (ph % 6 == 2) ? 1'b0 : 1'b1});
      if (ph % 3 == 0) write_reg(CFG_IDX_W'($urandom_range(2, 255)), $urandom);
      @(posedge clk_i);
      if (ph == 5) begin
        // receiver stalls while the sender floods single-channel frames
        tx_flood = 1'b1;
        hold_req_cnt++;
        n = 40;
        queue_frames(n, 1'b1);
      end else begin
        n = $urandom_range(20, 100);
        queue_frames(n, 1'b0);
      end
      if (cfg_capture) total += n;
      ph++;
    end
    wait_idle();
    if (mismatch_cnt == 0 && mono_due_q.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
